// ----- src/ledenc_pkg.sv -----
// shared types, constants and helpers of the addressable led encoder
package ledenc_pkg;

  localparam int COLOR_BITS = 8;
  localparam int PIXEL_BITS = 3 * COLOR_BITS;
  localparam int BIT_CNT_W  = $clog2(PIXEL_BITS);
  localparam int TICKS_W    = 16;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_ONE_HIGH  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ONE_LOW   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ZERO_HIGH = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ZERO_LOW  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_LATCH     = 3'd4;

  localparam logic [TICKS_W-1:0] RST_ONE_HIGH  = 16'd40;
  localparam logic [TICKS_W-1:0] RST_ONE_LOW   = 16'd20;
  localparam logic [TICKS_W-1:0] RST_ZERO_HIGH = 16'd20;
  localparam logic [TICKS_W-1:0] RST_ZERO_LOW  = 16'd40;
  localparam logic [TICKS_W-1:0] RST_LATCH     = 16'd2500;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_LATCH = 1'b1;

  typedef struct packed {
    logic [TICKS_W-1:0] one_high;
    logic [TICKS_W-1:0] one_low;
    logic [TICKS_W-1:0] zero_high;
    logic [TICKS_W-1:0] zero_low;
    logic [TICKS_W-1:0] latch_low;
  } cfg_t;

  typedef struct packed {
    logic                  latch;
    logic [PIXEL_BITS-1:0] grb;
  } cmd_t;

  // a zero duration is held for the shortest legal segment
  function automatic logic [TICKS_W-1:0] at_least_one(input logic [TICKS_W-1:0] v);
    at_least_one = (v == '0) ? TICKS_W'(1) : v;
  endfunction

endpackage

// ----- src/ledenc_front.sv -----
// front end: timing registers and classification of incoming items into commands
module ledenc_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wen,
  input  logic [ledenc_pkg::REG_IDX_W-1:0]    cfg_index,
  input  logic [ledenc_pkg::TICKS_W-1:0]      cfg_data,
  input  logic                                push,
  input  logic                                op,
  input  logic [ledenc_pkg::COLOR_BITS-1:0]   green,
  input  logic [ledenc_pkg::COLOR_BITS-1:0]   red,
  input  logic [ledenc_pkg::COLOR_BITS-1:0]   blue,
  input  logic                                q_full,
  output logic                                q_push,
  output ledenc_pkg::cmd_t                    q_cmd,
  output ledenc_pkg::cfg_t                    cfg
);
  import ledenc_pkg::*;

  logic [TICKS_W-1:0] wr_val;

  assign wr_val = at_least_one(cfg_data);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.one_high  <= RST_ONE_HIGH;
      cfg.one_low   <= RST_ONE_LOW;
      cfg.zero_high <= RST_ZERO_HIGH;
      cfg.zero_low  <= RST_ZERO_LOW;
      cfg.latch_low <= RST_LATCH;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_ONE_HIGH:  cfg.one_high  <= wr_val;
        REG_ONE_LOW:   cfg.one_low   <= wr_val;
        REG_ZERO_HIGH: cfg.zero_high <= wr_val;
        REG_ZERO_LOW:  cfg.zero_low  <= wr_val;
        REG_LATCH:     cfg.latch_low <= wr_val;
        default: ;
      endcase
    end
  end

  // pixel bits go out green first, msb first
  always_comb begin
    q_push       = push && !q_full;
    q_cmd.latch  = (op == OP_LATCH);
    q_cmd.grb    = (op == OP_LATCH) ? '0 : {green, red, blue};
  end

endmodule

// ----- src/ledenc_queue.sv -----
// short command queue between front end and segment sequencer
module ledenc_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  ledenc_pkg::cmd_t wr_cmd,
  output logic             full,
  input  logic             rd,
  output ledenc_pkg::cmd_t rd_cmd,
  output logic             empty
);
  import ledenc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  assign full   = (count == CNT_W'(DEPTH));
  assign empty  = (count == '0);
  assign rd_cmd = mem[rd_ptr];

  always_comb begin
    count_next = count;
    if (wr && !rd) count_next = count + CNT_W'(1);
    else if (!wr && rd) count_next = count - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (wr) mem[wr_ptr] <= wr_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (wr) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (rd) rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
    end
  end

endmodule

// ----- src/ledenc_back.sv -----
// back end: walks a command bit by bit and emits timed line segments
module ledenc_back (
  input  logic                           clk,
  input  logic                           rst,
  input  ledenc_pkg::cfg_t               cfg,
  input  ledenc_pkg::cmd_t               q_cmd,
  input  logic                           q_empty,
  output logic                           q_pop,
  output logic                           busy,
  output logic                           empty,
  input  logic                           pop,
  output logic                           level,
  output logic [ledenc_pkg::TICKS_W-1:0] ticks,
  output logic                           last
);
  import ledenc_pkg::*;

  logic                  out_valid;
  logic                  phase;
  logic [BIT_CNT_W-1:0]  bit_cnt;
  logic [PIXEL_BITS-1:0] shreg;
  logic                  load_ok;
  logic                  emit;
  logic                  seg_level;
  logic [TICKS_W-1:0]    seg_ticks;
  logic                  seg_last;
  logic                  cur_bit;
  logic                  final_bit;

  assign empty     = !out_valid;
  assign load_ok   = !out_valid || pop;
  assign cur_bit   = shreg[PIXEL_BITS-1];
  assign final_bit = (bit_cnt == BIT_CNT_W'(PIXEL_BITS - 1));

  always_comb begin
    q_pop     = 1'b0;
    emit      = 1'b0;
    seg_level = 1'b0;
    seg_ticks = cfg.latch_low;
    seg_last  = 1'b0;
    if (busy) begin
      emit      = load_ok;
      seg_level = !phase;
      if (!phase) seg_ticks = cur_bit ? cfg.one_high : cfg.zero_high;
      else        seg_ticks = cur_bit ? cfg.one_low : cfg.zero_low;
      seg_last  = phase && final_bit;
    end else if (!q_empty) begin
      if (q_cmd.latch) begin
        // latch gap goes straight to the output slot
        q_pop = load_ok;
        emit  = load_ok;
        seg_last = 1'b1;
      end else begin
        q_pop = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      phase     <= 1'b0;
      bit_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load_ok) out_valid <= emit;
      if (busy) begin
        if (load_ok) begin
          phase <= !phase;
          if (phase) begin
            bit_cnt <= bit_cnt + BIT_CNT_W'(1);
            if (final_bit) busy <= 1'b0;
          end
        end
      end else if (q_pop && !q_cmd.latch) begin
        busy    <= 1'b1;
        phase   <= 1'b0;
        bit_cnt <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy && load_ok && phase) shreg <= {shreg[PIXEL_BITS-2:0], 1'b0};
    else if (!busy && q_pop) shreg <= q_cmd.grb;
    if (load_ok && emit) begin
      level <= seg_level;
      ticks <= seg_ticks;
      last  <= seg_last;
    end
  end

endmodule

// ----- src/addressable_led_grb_encoder_top.sv -----
// top level of the addressable led grb encoder
//
// input channel: push/full queue of items; op selects a pixel (green, red,
// blue bytes) or a latch gap. a beat is taken when push is high and full low.
// output channel: empty/pop queue of line segments (level, ticks, last); the
// oldest segment sits on the ports while empty is low and leaves on pop.
// a pixel yields 48 segments (high then low per bit, green first, msb first),
// a latch yields one low segment; last marks the final segment of an item.
// timing registers are written through cfg_wen/cfg_index/cfg_data; the user
// must do so only while idle, which the block itself does not enforce.
// a value of zero is held as one tick. with the sequencer idle, a latch goes
// through the command queue and the output register; a pixel goes through the
// command queue and a load into the shift register, then the output register.
// one segment per cycle leaves while the receiver pops and no pixel loads.
// a command queue of QUEUE_DEPTH items parts intake from the sequencer, so
// input keeps flowing while the receiver stalls until that queue fills.
// reset (synchronous, active high) empties both queues and restores the
// default timing registers.
module addressable_led_grb_encoder_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wen,
  input  logic [ledenc_pkg::REG_IDX_W-1:0]    cfg_index,
  input  logic [ledenc_pkg::TICKS_W-1:0]      cfg_data,
  input  logic                                push,
  output logic                                full,
  input  logic                                op,
  input  logic [ledenc_pkg::COLOR_BITS-1:0]   green,
  input  logic [ledenc_pkg::COLOR_BITS-1:0]   red,
  input  logic [ledenc_pkg::COLOR_BITS-1:0]   blue,
  output logic                                empty,
  input  logic                                pop,
  output logic                                level,
  output logic [ledenc_pkg::TICKS_W-1:0]      ticks,
  output logic                                last
);
  import ledenc_pkg::*;

  cfg_t cfg;
  cmd_t wr_cmd;
  cmd_t rd_cmd;
  logic q_push;
  logic q_pop;
  logic q_empty;
  logic busy;

  ledenc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .op        (op),
    .green     (green),
    .red       (red),
    .blue      (blue),
    .q_full    (full),
    .q_push    (q_push),
    .q_cmd     (wr_cmd),
    .cfg       (cfg)
  );

  ledenc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (q_push),
    .wr_cmd (wr_cmd),
    .full   (full),
    .rd     (q_pop),
    .rd_cmd (rd_cmd),
    .empty  (q_empty)
  );

  ledenc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_cmd   (rd_cmd),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .busy    (busy),
    .empty   (empty),
    .pop     (pop),
    .level   (level),
    .ticks   (ticks),
    .last    (last)
  );

`ifndef SYNTHESIS
  a_ticks_nonzero : assert property (@(posedge clk) disable iff (rst)
    !empty |-> ticks != '0) else $error("segment with zero ticks");

  a_high_not_last : assert property (@(posedge clk) disable iff (rst)
    !empty && level |-> !last) else $error("high segment marked last");

  a_no_pop_busy : assert property (@(posedge clk) disable iff (rst)
    busy |-> !q_pop) else $error("queue popped while sequencer busy");

  a_pop_needs_item : assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty) else $error("pop from empty command queue");
`endif

endmodule

// ----- tb/sv/testbench.sv -----
// testbench of the addressable led grb encoder: queued driver, segment monitor and predictor
`timescale 1ns / 100ps

module testbench;
  import ledenc_pkg::*;

  localparam int STALL_LIMIT  = 4000;
  localparam int SETTLE       = 8;

  typedef struct packed {
    logic                  op;
    logic [COLOR_BITS-1:0] green;
    logic [COLOR_BITS-1:0] red;
    logic [COLOR_BITS-1:0] blue;
  } led_item_t;

  typedef struct packed {
    logic               level;
    logic [TICKS_W-1:0] ticks;
    logic               last;
  } segment_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wen = 1'b0;
  logic [REG_IDX_W-1:0]  cfg_index = '0;
  logic [TICKS_W-1:0]    cfg_data = '0;
  logic                  push = 1'b0;
  logic                  full;
  logic                  op = OP_PIXEL;
  logic [COLOR_BITS-1:0] green = '0;
  logic [COLOR_BITS-1:0] red = '0;
  logic [COLOR_BITS-1:0] blue = '0;
  logic                  empty;
  logic                  pop = 1'b0;
  logic                  level;
  logic [TICKS_W-1:0]    ticks;
  logic                  last;

  led_item_t items_to_send[$];
  segment_t  segments_due[$];
  segment_t  seg_want;
  cfg_t      timing;
  int        send_idle_pct = 7;
  int        pop_idle_pct = 59;
  int        errors = 0;
  int        seg_count = 0;
  int        stall_cycles = 0;

  addressable_led_grb_encoder_top dut (
    .clk(clk), .rst(rst),
    .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .push(push), .full(full), .op(op), .green(green), .red(red), .blue(blue),
    .empty(empty), .pop(pop), .level(level), .ticks(ticks), .last(last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // a zero register still holds the line for one tick
  function automatic logic [TICKS_W-1:0] line_ticks(input logic [TICKS_W-1:0] t);
    line_ticks = (t == '0) ? TICKS_W'(1) : t;
  endfunction

  function automatic void expand_item(input led_item_t item);
    logic [PIXEL_BITS-1:0] grb;
    segment_t seg;
    grb = {item.green, item.red, item.blue};
    if (item.op == OP_LATCH) begin
      seg.level = 1'b0;
      seg.ticks = line_ticks(timing.latch_low);
      seg.last  = 1'b1;
      segments_due.push_back(seg);
    end else begin
      for (int b = PIXEL_BITS - 1; b >= 0; b--) begin
        seg.level = 1'b1;
        seg.ticks = line_ticks(grb[b] ? timing.one_high : timing.zero_high);
        seg.last  = 1'b0;
        segments_due.push_back(seg);
        seg.level = 1'b0;
        seg.ticks = line_ticks(grb[b] ? timing.one_low : timing.zero_low);
        seg.last  = (b == 0);
        segments_due.push_back(seg);
      end
    end
  endfunction

  function automatic void flag_error(input string msg);
    errors++;
    $display("%0t: %s", $time, msg);
  endfunction

  function automatic logic [COLOR_BITS-1:0] random_byte();
    case ($urandom_range(5))
      0: random_byte = '0;
      1: random_byte = '1;
      default: random_byte = COLOR_BITS'($urandom);
    endcase
  endfunction

  function automatic led_item_t random_item();
    led_item_t item;
    item.op    = ($urandom_range(3) == 0) ? OP_LATCH : OP_PIXEL;
    item.green = random_byte();
    item.red   = random_byte();
    item.blue  = random_byte();
    return item;
  endfunction

  function automatic void add_item(input logic o, input logic [COLOR_BITS-1:0] g,
                                   input logic [COLOR_BITS-1:0] r,
                                   input logic [COLOR_BITS-1:0] b);
    led_item_t item;
    item.op = o;
    item.green = g;
    item.red = r;
    item.blue = b;
    items_to_send.push_back(item);
  endfunction

  // driver: holds a beat while full, otherwise offers the next item or idles
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        expand_item(items_to_send.pop_front());
      end
      if (!(push && full)) begin
        if (items_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          push  <= 1'b1;
          op    <= items_to_send[0].op;
          green <= items_to_send[0].green;
          red   <= items_to_send[0].red;
          blue  <= items_to_send[0].blue;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (segments_due.size() == 0) begin
          flag_error($sformatf("unexpected segment level %0d ticks %0d last %0d",
                               level, ticks, last));
        end else begin
          seg_want = segments_due.pop_front();
          if (level !== seg_want.level)
            flag_error($sformatf("segment %0d level expected %0d actual %0d",
                                 seg_count, seg_want.level, level));
          if (ticks !== seg_want.ticks)
            flag_error($sformatf("segment %0d ticks expected %0d actual %0d",
                                 seg_count, seg_want.ticks, ticks));
          if (last !== seg_want.last)
            flag_error($sformatf("segment %0d last expected %0d actual %0d",
                                 seg_count, seg_want.last, last));
        end
        seg_count++;
      end
      pop <= ($urandom_range(99) >= pop_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles + 1 >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [TICKS_W-1:0] data);
    @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_ONE_HIGH:  timing.one_high = data;
      REG_ONE_LOW:   timing.one_low = data;
      REG_ZERO_HIGH: timing.zero_high = data;
      REG_ZERO_LOW:  timing.zero_low = data;
      REG_LATCH:     timing.latch_low = data;
      default: ;
    endcase
  endtask

  task automatic load_timing(input cfg_t t);
    write_reg(REG_ONE_HIGH, t.one_high);
    write_reg(REG_ONE_LOW, t.one_low);
    write_reg(REG_ZERO_HIGH, t.zero_high);
    write_reg(REG_ZERO_LOW, t.zero_low);
    write_reg(REG_LATCH, t.latch_low);
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  task automatic wait_drained();
    while (items_to_send.size() != 0 || segments_due.size() != 0 || push)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic run_phase(input cfg_t t, input int send_pct, input int pop_pct, input int n);
    wait_drained();
    load_timing(t);
    send_idle_pct = send_pct;
    pop_idle_pct = pop_pct;
    repeat (n) items_to_send.push_back(random_item());
  endtask

  initial begin
    cfg_t t;
    timing.one_high  = RST_ONE_HIGH;
    timing.one_low   = RST_ONE_LOW;
    timing.zero_high = RST_ZERO_HIGH;
    timing.zero_low  = RST_ZERO_LOW;
    timing.latch_low = RST_LATCH;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // indexes past the last register must leave the timing alone
    for (int idx = REG_LATCH + 1; idx < 2 ** REG_IDX_W; idx++)
      write_reg(REG_IDX_W'(idx), TICKS_W'($urandom));
    @(posedge clk);
    cfg_wen <= 1'b0;

    add_item(OP_PIXEL, 8'h00, 8'h00, 8'h00);
    add_item(OP_PIXEL, 8'hff, 8'hff, 8'hff);
    add_item(OP_PIXEL, 8'h80, 8'h00, 8'h00);
    add_item(OP_PIXEL, 8'h00, 8'h00, 8'h01);
    add_item(OP_PIXEL, 8'h01, 8'h80, 8'h00);
    add_item(OP_PIXEL, 8'haa, 8'h55, 8'haa);
    add_item(OP_PIXEL, 8'h55, 8'haa, 8'h55);
    add_item(OP_LATCH, 8'hff, 8'hff, 8'hff);
    add_item(OP_LATCH, 8'h00, 8'h00, 8'h00);
    add_item(OP_LATCH, 8'h5a, 8'hc3, 8'h81);
    add_item(OP_PIXEL, 8'hff, 8'h00, 8'hff);
    add_item(OP_PIXEL, 8'h00, 8'hff, 8'h00);
    add_item(OP_PIXEL, 8'h0f, 8'hf0, 8'h3c);
    add_item(OP_LATCH, 8'h00, 8'hff, 8'h00);
    add_item(OP_PIXEL, 8'h7f, 8'hfe, 8'h81);

    // shortest legal segments
    t = '{16'd1, 16'd1, 16'd1, 16'd1, 16'd1};
    run_phase(t, 7, 59, 19);
    // longest segments
    t = '{16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff};
    run_phase(t, 7, 59, 19);
    // zero registers fall back to one tick
    t = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
    run_phase(t, 59, 7, 19);
    t.one_high  = TICKS_W'($urandom);
    t.one_low   = 16'd0;
    t.zero_high = TICKS_W'($urandom);
    t.zero_low  = TICKS_W'($urandom);
    t.latch_low = TICKS_W'($urandom_range(1, 65535));
    run_phase(t, 59, 7, 19);
    t.one_high  = TICKS_W'($urandom_range(30, 50));
    t.one_low   = TICKS_W'($urandom_range(10, 30));
    t.zero_high = TICKS_W'($urandom_range(10, 30));
    t.zero_low  = TICKS_W'($urandom_range(30, 50));
    t.latch_low = 16'd0;
    run_phase(t, 0, 0, 19);
    t = '{RST_ONE_HIGH, RST_ONE_LOW, RST_ZERO_HIGH, RST_ZERO_LOW, RST_LATCH};
    run_phase(t, 0, 0, 19);

    wait_drained();
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- addressable_led_grb_encoder_top.f -----
src/ledenc_pkg.sv
src/ledenc_front.sv
src/ledenc_queue.sv
src/ledenc_back.sv
src/addressable_led_grb_encoder_top.sv
tb/sv/testbench.sv
